@@ hw/rtl/settled_input_change_reporter_defines.svh @@
// Assertion macros shared by the settled input change reporter RTL.
`ifndef SETTLED_INPUT_CHANGE_REPORTER_DEFINES_SVH
`define SETTLED_INPUT_CHANGE_REPORTER_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define SICR_ASSERT_HOLDS(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define SICR_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/sicr_pkg.sv @@
// Types and constants shared by the settled input change reporter.
`default_nettype none

package sicr_pkg;

  // command codes
  localparam logic [1:0] CMD_EDGE    = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_POLL    = 2'd2;
  localparam logic [1:0] CMD_COLLECT = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_PIN_COUNT    = 2'd0;
  localparam logic [1:0] CFG_SETTLE_TICKS = 2'd1;
  localparam logic [1:0] CFG_MAX_RETRIES  = 2'd2;

  localparam int unsigned PIN_MAX = 32;

  localparam logic [5:0] DEFAULT_PINS  = 6'd10;
  localparam logic [7:0] DEFAULT_TICKS = 8'd25;
  localparam logic [5:0] WIDE_LIMIT    = 6'd16;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] pin_levels;
  } in_word_t;

  typedef struct packed {
    logic [31:0] bitmap;
    logic        wide_format;
  } out_word_t;

  // report handed from the front end to the queue
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } rpt_push_t;

endpackage

`default_nettype wire

@@ hw/rtl/sicr_front.sv @@
// Front end: config registers, edge counting, settle window control, report decision.
`default_nettype none
`include "settled_input_change_reporter_defines.svh"

module sicr_front import sicr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  in_word_t   in_word,
  input  logic       in_ready,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  output rpt_push_t  push
);

  logic [5:0]  pin_count_r, pin_count_nxt;
  logic [7:0]  settle_ticks_r, settle_ticks_nxt;
  logic [7:0]  max_retries_r, max_retries_nxt;
  logic        settling_r, settling_nxt;
  logic [7:0]  ticks_left_r, ticks_left_nxt;
  logic [7:0]  retries_used_r, retries_used_nxt;
  logic        force_report_r, force_report_nxt;
  logic [31:0] edge_total_r, edge_total_nxt;
  logic [31:0] ack_total_r, ack_total_nxt;
  logic [31:0] win_start_r, win_start_nxt;
  logic [31:0] last_reported_r, last_reported_nxt;

  logic        accept;
  logic [5:0]  pins_eff;
  logic [31:0] pin_mask;
  logic [31:0] bmp;
  logic [7:0]  window_len;
  logic [7:0]  ticks_dec;
  logic        open_win;

  assign accept = in_valid && in_ready;

  always_comb begin
    pins_eff = pin_count_r;
    if (pin_count_r == 6'd0) begin
      pins_eff = DEFAULT_PINS;
    end
    if (pin_count_r > 6'(PIN_MAX)) begin
      pins_eff = 6'(PIN_MAX);
    end
  end

  // pins_eff is 1..PIN_MAX, so the shift amount stays below 32
  assign pin_mask   = 32'hFFFF_FFFF >> (6'(PIN_MAX) - pins_eff);
  assign bmp        = in_word.pin_levels & pin_mask;
  assign window_len = (settle_ticks_r == 8'd0) ? DEFAULT_TICKS : settle_ticks_r;
  assign ticks_dec  = (ticks_left_r != 8'd0) ? ticks_left_r - 8'd1 : 8'd0;

  always_comb begin
    pin_count_nxt     = pin_count_r;
    settle_ticks_nxt  = settle_ticks_r;
    max_retries_nxt   = max_retries_r;
    settling_nxt      = settling_r;
    ticks_left_nxt    = ticks_left_r;
    retries_used_nxt  = retries_used_r;
    force_report_nxt  = force_report_r;
    edge_total_nxt    = edge_total_r;
    ack_total_nxt     = ack_total_r;
    win_start_nxt     = win_start_r;
    last_reported_nxt = last_reported_r;
    open_win          = 1'b0;
    push.valid        = 1'b0;
    push.word.bitmap  = bmp;
    push.word.wide_format = (pins_eff > WIDE_LIMIT);

    if (cfg_we) begin
      case (cfg_index)
        CFG_PIN_COUNT:    pin_count_nxt    = cfg_wdata[5:0];
        CFG_SETTLE_TICKS: settle_ticks_nxt = cfg_wdata;
        CFG_MAX_RETRIES:  max_retries_nxt  = cfg_wdata;
        default: ;
      endcase
    end

    if (accept) begin
      case (in_word.command)
        CMD_EDGE: begin
          edge_total_nxt = edge_total_r + 32'd1;
        end
        CMD_POLL, CMD_COLLECT: begin
          if (!settling_r &&
              (in_word.command == CMD_COLLECT || ack_total_r != edge_total_r)) begin
            force_report_nxt = (in_word.command == CMD_COLLECT);
            retries_used_nxt = 8'd0;
            open_win         = 1'b1;
          end
        end
        CMD_TICK: begin
          if (settling_r) begin
            ticks_left_nxt = ticks_dec;
            if (ticks_dec == 8'd0) begin
              if (edge_total_r != win_start_r && retries_used_r < max_retries_r) begin
                retries_used_nxt = retries_used_r + 8'd1;
                open_win         = 1'b1;
              end else begin
                settling_nxt = 1'b0;
                if (force_report_r || bmp != last_reported_r) begin
                  last_reported_nxt = bmp;
                  push.valid        = 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end

    if (open_win) begin
      ack_total_nxt  = edge_total_r;
      win_start_nxt  = edge_total_r;
      ticks_left_nxt = window_len;
      settling_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_count_r     <= DEFAULT_PINS;
      settle_ticks_r  <= DEFAULT_TICKS;
      max_retries_r   <= 8'd0;
      settling_r      <= 1'b0;
      ticks_left_r    <= 8'd0;
      retries_used_r  <= 8'd0;
      force_report_r  <= 1'b0;
      edge_total_r    <= 32'd0;
      ack_total_r     <= 32'd0;
      win_start_r     <= 32'd0;
      last_reported_r <= 32'd0;
    end else begin
      pin_count_r     <= pin_count_nxt;
      settle_ticks_r  <= settle_ticks_nxt;
      max_retries_r   <= max_retries_nxt;
      settling_r      <= settling_nxt;
      ticks_left_r    <= ticks_left_nxt;
      retries_used_r  <= retries_used_nxt;
      force_report_r  <= force_report_nxt;
      edge_total_r    <= edge_total_nxt;
      ack_total_r     <= ack_total_nxt;
      win_start_r     <= win_start_nxt;
      last_reported_r <= last_reported_nxt;
    end
  end

  `SICR_ASSERT_HOLDS(a_push_from_tick, push.valid |-> (accept && in_word.command == CMD_TICK), "report without an accepted tick")
  `SICR_ASSERT_NEVER(a_settle_zero_ticks, settling_r && ticks_left_r == 8'd0, "settling with no ticks left")
  `SICR_ASSERT_HOLDS(a_push_ends_settle, push.valid |=> !settling_r, "still settling after report")
  `SICR_ASSERT_HOLDS(a_last_tracks_push, push.valid |=> (last_reported_r == $past(push.word.bitmap)), "last report not updated")

endmodule

`default_nettype wire

@@ hw/rtl/sicr_fifo.sv @@
// Back end: short report queue that feeds the result channel.
`default_nettype none
`include "settled_input_change_reporter_defines.svh"

module sicr_fifo import sicr_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  rpt_push_t push,
  output logic      full,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  out_word_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == FULL_CNT);
  assign out_valid = (count_r != '0);
  assign out_word  = mem_r[rd_ptr_r];
  assign do_push   = push.valid && !full;
  assign do_pop    = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `SICR_ASSERT_NEVER(a_push_when_full, push.valid && full, "report dropped on full queue")
  `SICR_ASSERT_NEVER(a_count_range, count_r > FULL_CNT, "queue count overflow")
  `SICR_ASSERT_HOLDS(a_ptr_gap, (count_r == '0 || count_r == FULL_CNT) |-> (wr_ptr_r == rd_ptr_r), "pointers disagree with count")

endmodule

`default_nettype wire

@@ hw/rtl/settled_input_change_reporter.sv @@
// Top level of the settled input change reporter.
// Input channel (in_valid/in_ready/in_word): one word per command: edge event,
//   tick, poll or collect, with the current pin levels alongside.
// Result channel (out_valid/out_ready/out_word): a settled bitmap, masked to the
//   effective pin count, plus the wide format flag (more than 16 pins).
// Config port (cfg_we/cfg_index/cfg_wdata): 0 pin_count, 1 settle_ticks,
//   2 max_retries; other indexes are dropped.
// Throughput: one input word per cycle while the report queue is not full;
//   every command is a single counter and compare update in the front end.
// Report path: a report from an accepted tick is written into the report queue;
//   out_valid and out_word come from the head of that queue.
// Stall: reports pile into a QUEUE_DEPTH-entry queue; in_ready drops only when
//   that queue is full, so the front keeps taking edges and ticks meanwhile.
// Reset (rst_n low, synchronous): all counters and totals clear, queue empties,
//   registers return to 10 pins, 25 ticks, no retries.
`default_nettype none

module settled_input_change_reporter import sicr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_word,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  rpt_push_t push;
  logic      q_full;

  // each accepted word yields at most one report, so free space is enough
  assign in_ready = !q_full;

  sicr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_ready  (in_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push)
  );

  sicr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire
